// ===== hw/rtl/cse_pkg.sv =====
// Shared types and constants of the cubic spline evaluator.
`default_nettype none
package cse_pkg;
	typedef enum logic [0:0] {
		OP_LOAD = 1'b0,
		OP_EVAL = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		MODE_PLAIN    = 2'd0,
		MODE_PERIODIC = 2'd1,
		MODE_NATURAL  = 2'd2,
		MODE_SPARE    = 2'd3
	} mode_t;

	localparam logic [0:0] REG_METHOD_MODE = 1'b0;
	localparam logic [0:0] REG_KNOT_COUNT  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ0,
		ST_READL,
		ST_WRAP,
		ST_RDC,
		ST_RDC1,
		ST_CHECK,
		ST_BRD,
		ST_BCMP,
		ST_FETCH,
		ST_DX,
		ST_MUL,
		ST_ACC,
		ST_OUT
	} state_t;
endpackage
`default_nettype wire

// ===== hw/rtl/cubic_spline_evaluator.sv =====
// Top level of the cubic spline evaluator.
// Usage: requests arrive on the s_axis channel: tuser carries the operation
// (0 load, 1 evaluate); tdata packs knot_index, knot_pos, knot_value,
// lin_coef, quad_coef, cubic_coef and sample from bit 0 up. A load writes one
// knot entry into the five coefficient memories and gives no result. An
// evaluate gives one result on m_axis: tdata is result_value, tuser is the
// saturation flag. Requests pass through a four-entry queue; an idle back end
// takes a request out in the cycle after it is accepted.
// An evaluate runs the bit-serial periodic remainder when wrap applies, then
// tests the cached interval and, if it no longer holds, bisects (one to six
// steps over 64 knots); Horner runs on one 33 by 32 multiplier. The next
// request leaves the queue in the cycle after the result is accepted, so
// evaluates go one by one; loads go at one a cycle while the back end idles.
// The result is held in the output register until m_axis_tready is seen;
// meanwhile the queue fills and s_axis_tready falls. Reset clears the queue,
// the cached interval and sets method_mode 2, knot_count 2; table contents
// are undefined until loaded. Configuration is written through cfg_we,
// cfg_index and cfg_data while no request is in flight.
`default_nettype none
module cubic_spline_evaluator #(
	parameter int MAX_KNOTS = 64,
	parameter int FRAC_BITS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [0:0]   cfg_index,
	input  wire logic [6:0]   cfg_data,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// knot_index, knot_pos, knot_value, lin_coef, quad_coef, cubic_coef, sample
	input  wire logic [199:0] s_axis_tdata,
	// operation
	input  wire logic [0:0]   s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// result_value
	output logic      [31:0]  m_axis_tdata,
	// saturated
	output logic      [0:0]   m_axis_tuser
);
	logic [1:0] mode_q;
	logic [6:0] kcount_q;
	logic q_valid, q_pop;
	logic [198:0] q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= cse_pkg::MODE_NATURAL;
			kcount_q <= 7'd2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cse_pkg::REG_METHOD_MODE: mode_q <= cfg_data[1:0];
				cse_pkg::REG_KNOT_COUNT:  kcount_q <= cfg_data;
				default: ;
			endcase
		end
	end

	cse_front #(.DEPTH(4)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_data({s_axis_tdata[197:0], s_axis_tuser}),
		.q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
	);

	cse_back #(.MAX_KNOTS(MAX_KNOTS), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
		.mode(mode_q), .kcount(kcount_q),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_value(m_axis_tdata), .out_sat(m_axis_tuser[0])
	);
endmodule
`default_nettype wire

// ===== hw/rtl/cse_ram.sv =====
// Generic single-port write, single-port registered-read RAM.
`default_nettype none
module cse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== hw/rtl/cse_front.sv =====
// Front end: accepts requests and pushes them into a short queue.
`default_nettype none
module cse_front #(
	parameter int DEPTH = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [198:0] in_data,
	output logic              q_valid,
	input  wire logic         q_pop,
	output logic      [198:0] q_data
);
	localparam int AW = $clog2(DEPTH);
	logic [198:0] buf_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0] cnt_q;
	logic push;

	assign in_ready = (cnt_q != DEPTH[AW:0]);
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != '0);
	assign q_data = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (q_pop && q_valid) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + {{AW{1'b0}}, push} - {{AW{1'b0}}, q_pop && q_valid};
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DEPTH[AW:0]) else $error("queue overflow");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |=> (cnt_q <= 1)) else $error("pop from empty queue");
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == DEPTH[AW:0]) |-> !in_ready) else $error("full queue accepts");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/cse_back.sv =====
// Back end: knot tables, wrap, interval search and Horner evaluation.
`default_nettype none
module cse_back #(
	parameter int MAX_KNOTS = 64,
	parameter int FRAC_BITS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         q_valid,
	output logic              q_pop,
	input  wire logic [198:0] q_data,
	input  wire logic [1:0]   mode,
	input  wire logic [6:0]   kcount,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic      [31:0]  out_value,
	output logic              out_sat
);
	localparam int AW = $clog2(MAX_KNOTS);
	localparam int NW = AW + 1;
	localparam logic signed [64:0] RND_HALF = 65'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [64:0] SAT_HI = 65'sd2147483647;
	localparam logic signed [64:0] SAT_LO = -65'sd2147483648;

	cse_pkg::state_t state_q, state_d;
	logic [AW-1:0] raddr, waddr, cache_q, lo_q, lo_d, mid;
	logic [NW-1:0] n, hi_q, hi_d;
	logic [31:0] rpos, rval, rlin, rquad, rcub;
	logic we;
	logic [5:0] widx;
	logic signed [31:0] sample;
	logic signed [32:0] ul_q, x0_q, span_q, rpos_x, span_c, diff_c;
	logic [31:0] mag_q, rem_q, rem_sub, wrap_r;
	logic [32:0] rem_trial;
	logic [5:0] bit_q;
	logic neg_q, c_ok_q, hit, left_q, wrap_en;
	logic signed [32:0] dx_q;
	logic signed [31:0] acc_q, mul_acc;
	logic signed [64:0] prod_s1, rsum, shf, tot;
	logic [1:0] stg_q;
	logic sat_q;
	logic [31:0] coef;
	logic signed [31:0] satv;
	logic clip;

	// Knot count clamped to 1..MAX_KNOTS.
	always_comb begin
		if (kcount == 7'd0) begin
			n = NW'(1);
		end else if ({25'd0, kcount} > MAX_KNOTS) begin
			n = NW'(MAX_KNOTS);
		end else begin
			n = NW'(kcount);
		end
	end

	assign sample = q_data[198:167];
	assign widx = q_data[6:1];
	assign waddr = AW'(widx);
	assign we = q_valid && (state_q == cse_pkg::ST_IDLE)
		&& (q_data[0] == cse_pkg::OP_LOAD) && ({26'd0, widx} < MAX_KNOTS);

	cse_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_pos (.clk(clk), .we(we),
		.waddr(waddr), .wdata(q_data[38:7]), .raddr(raddr), .rdata(rpos));
	cse_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_val (.clk(clk), .we(we),
		.waddr(waddr), .wdata(q_data[70:39]), .raddr(raddr), .rdata(rval));
	cse_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_lin (.clk(clk), .we(we),
		.waddr(waddr), .wdata(q_data[102:71]), .raddr(raddr), .rdata(rlin));
	cse_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_quad (.clk(clk), .we(we),
		.waddr(waddr), .wdata(q_data[134:103]), .raddr(raddr), .rdata(rquad));
	cse_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_cub (.clk(clk), .we(we),
		.waddr(waddr), .wdata(q_data[166:135]), .raddr(raddr), .rdata(rcub));

	assign rpos_x = {rpos[31], rpos};
	assign span_c = rpos_x - x0_q;
	assign diff_c = ul_q - x0_q;
	assign wrap_en = (mode == cse_pkg::MODE_PERIODIC) && (n > NW'(1)) && (span_c > 33'sd0);

	// Restoring remainder step of the periodic wrap, most significant bit first.
	assign rem_trial = {rem_q, mag_q[31]};
	assign rem_sub = rem_trial[31:0] - span_q[31:0];
	assign wrap_r = (neg_q && rem_q != '0) ? span_q[31:0] - rem_q : rem_q;

	// Bisection step and cache test.
	assign mid = AW'(({1'b0, lo_q} + hi_q) >> 1);
	always_comb begin
		if (ul_q < rpos_x) begin
			lo_d = lo_q;
			hi_d = {1'b0, mid};
		end else begin
			lo_d = mid;
			hi_d = hi_q;
		end
	end
	assign hit = c_ok_q && !((({1'b0, cache_q} + NW'(1)) < n) && (rpos_x < ul_q));

	always_comb begin
		unique case (state_q)
			cse_pkg::ST_IDLE:  raddr = '0;
			cse_pkg::ST_READ0: raddr = AW'(n - NW'(1));
			cse_pkg::ST_RDC:   raddr = cache_q;
			cse_pkg::ST_RDC1:  raddr = cache_q + AW'(1);
			cse_pkg::ST_BRD:   raddr = mid;
			default:           raddr = lo_q;
		endcase
	end

	// Rounded shift of the product plus coefficient, saturated.
	always_comb begin
		mul_acc = (stg_q == 2'd0) ? (left_q ? 32'sd0 : $signed(rcub)) : acc_q;
		rsum = prod_s1 + RND_HALF;
		shf = rsum >>> FRAC_BITS;
		unique case (stg_q)
			2'd0: coef = rquad;
			2'd1: coef = rlin;
			default: coef = rval;
		endcase
		tot = shf + $signed({{33{coef[31]}}, coef});
		clip = 1'b0;
		if (tot > SAT_HI) begin
			satv = 32'sh7fffffff;
			clip = 1'b1;
		end else if (tot < SAT_LO) begin
			satv = 32'sh80000000;
			clip = 1'b1;
		end else begin
			satv = tot[31:0];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cse_pkg::ST_IDLE:
				if (q_valid && (q_data[0] == cse_pkg::OP_EVAL)) begin
					state_d = cse_pkg::ST_READ0;
				end
			cse_pkg::ST_READ0: state_d = cse_pkg::ST_READL;
			cse_pkg::ST_READL: state_d = wrap_en ? cse_pkg::ST_WRAP : cse_pkg::ST_RDC;
			cse_pkg::ST_WRAP:
				if (bit_q == '0) begin
					state_d = cse_pkg::ST_RDC;
				end
			cse_pkg::ST_RDC:   state_d = cse_pkg::ST_RDC1;
			cse_pkg::ST_RDC1:  state_d = cse_pkg::ST_CHECK;
			cse_pkg::ST_CHECK: state_d = hit ? cse_pkg::ST_FETCH : cse_pkg::ST_BRD;
			cse_pkg::ST_BRD:   state_d = cse_pkg::ST_BCMP;
			cse_pkg::ST_BCMP:
				if (hi_d > {1'b0, lo_d} + NW'(1)) begin
					state_d = cse_pkg::ST_BRD;
				end else begin
					state_d = cse_pkg::ST_FETCH;
				end
			cse_pkg::ST_FETCH: state_d = cse_pkg::ST_DX;
			cse_pkg::ST_DX:    state_d = cse_pkg::ST_MUL;
			cse_pkg::ST_MUL:   state_d = cse_pkg::ST_ACC;
			cse_pkg::ST_ACC:   state_d = (stg_q == 2'd2) ? cse_pkg::ST_OUT : cse_pkg::ST_MUL;
			cse_pkg::ST_OUT:
				if (out_ready) begin
					state_d = cse_pkg::ST_IDLE;
				end
			default: state_d = cse_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop = (state_q == cse_pkg::ST_IDLE) && q_valid;
		out_valid = (state_q == cse_pkg::ST_OUT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cse_pkg::ST_IDLE;
			cache_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == cse_pkg::ST_FETCH) begin
				cache_q <= lo_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			cse_pkg::ST_IDLE: begin
				ul_q <= {sample[31], sample};
				sat_q <= 1'b0;
				stg_q <= 2'd0;
			end
			cse_pkg::ST_READ0: x0_q <= rpos_x;
			cse_pkg::ST_READL: begin
				span_q <= span_c;
				neg_q <= diff_c[32];
				mag_q <= diff_c[32] ? 32'(-diff_c) : diff_c[31:0];
				rem_q <= '0;
				bit_q <= 6'd32;
			end
			cse_pkg::ST_WRAP:
				if (bit_q != '0) begin
					if (rem_trial >= {1'b0, span_q[31:0]}) begin
						rem_q <= rem_sub;
					end else begin
						rem_q <= rem_trial[31:0];
					end
					mag_q <= {mag_q[30:0], 1'b0};
					bit_q <= bit_q - 6'd1;
				end else begin
					ul_q <= x0_q + $signed({1'b0, wrap_r});
				end
			cse_pkg::ST_RDC1: c_ok_q <= ({1'b0, cache_q} < n) && !(ul_q < rpos_x);
			cse_pkg::ST_CHECK:
				if (hit) begin
					lo_q <= cache_q;
				end else begin
					lo_q <= '0;
					hi_q <= n;
				end
			cse_pkg::ST_BCMP: begin
				lo_q <= lo_d;
				hi_q <= hi_d;
			end
			cse_pkg::ST_DX: begin
				dx_q <= ul_q - rpos_x;
				left_q <= (mode == cse_pkg::MODE_NATURAL) && (ul_q < x0_q);
			end
			cse_pkg::ST_MUL: prod_s1 <= 65'(dx_q) * 65'(mul_acc);
			cse_pkg::ST_ACC: begin
				acc_q <= satv;
				sat_q <= sat_q | clip;
				stg_q <= stg_q + 2'd1;
			end
			default: ;
		endcase
	end

	assign out_value = acc_q;
	assign out_sat = sat_q;

`ifndef SYNTHESIS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_value)))
		else $error("result dropped");
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (state_q == cse_pkg::ST_IDLE)) else $error("pop while busy");
	a_cache_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cse_pkg::ST_OUT) |-> ({1'b0, cache_q} < n))
		else $error("interval out of range");
`endif
endmodule
`default_nettype wire
